FILE: hdl/riw_pkg.sv
package riw_pkg;

  // Width of the age and settle counters.
  localparam int unsigned TimerWidth = 16;
  // Width of the configuration registers.
  localparam int unsigned CfgWidth = 16;
  // Counters and configuration values are compared at the wider of the two widths.
  localparam int unsigned CmpWidth = (TimerWidth > CfgWidth) ? TimerWidth : CfgWidth;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned InDataWidth   = 8;
  localparam int unsigned OutDataWidth  = 16;

  localparam logic [CfgWidth-1:0] WdtTimeoutReset = CfgWidth'(500);
  localparam logic [CfgWidth-1:0] SettleTimeReset = CfgWidth'(300);

  typedef logic [TimerWidth-1:0] timer_t;
  typedef logic [CmpWidth-1:0]   cmp_t;

  typedef enum logic [1:0] {
    OP_PERMIT = 2'd0,
    OP_HEALTH = 2'd1,
    OP_TICK   = 2'd2
  } opcode_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_WDT_TIMEOUT = 2'd0,
    REG_SETTLE_TIME = 2'd1
  } reg_index_e;

  typedef enum logic [1:0] {
    FAULT_NONE       = 2'd0,
    FAULT_WELDED     = 2'd1,
    FAULT_NOT_CLOSED = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    CAUSE_OK    = 2'd0,
    CAUSE_STALE = 2'd1,
    CAUSE_FALSE = 2'd2
  } cause_e;

  // One result word, first field in the highest bits.
  typedef struct packed {
    logic   status_event;
    cause_e health_cause;
    cause_e permit_cause;
    fault_e fault_code;
    logic   mismatch_now;
    logic   settled_now;
    logic   feedback_seen;
    logic   relay_drive;
  } result_t;

endpackage

FILE: hdl/relay_interlock_watchdog_top.sv
// A result word appears on the master side in the cycle after its input word is taken.
// Throughput: one input word per cycle while the master side keeps taking results; all work
// is one combinational pass between the state registers and a single output register,
// which is refilled as it drains. Reset (rst_ni low, asynchronous): relay open, both
// inputs unseen, counters zero, output empty, watchdog_timeout 500 and settle_time 300.
module relay_interlock_watchdog_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [riw_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [riw_pkg::CfgWidth-1:0]          cfg_data_i,
  // Input words.
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [0] message_value, [1] feedback_level, [2] feedback_valid, rest zero.
  input  logic [riw_pkg::InDataWidth-1:0]       s_axis_tdata_i,
  // [1:0] opcode.
  input  logic [1:0]                            s_axis_tuser_i,
  // Result words.
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [0] relay_drive, [1] feedback_seen, [2] settled_now, [3] mismatch_now,
  // [5:4] fault_code, [7:6] permit_cause, [9:8] health_cause, [10] status_event, rest zero.
  output logic [riw_pkg::OutDataWidth-1:0]      m_axis_tdata_o
);

  localparam int unsigned ResWidth = $bits(riw_pkg::result_t);

  // Configuration registers.
  logic [riw_pkg::CfgWidth-1:0] wdt_timeout_q, settle_time_q;

  // Interlock state.
  logic            permit_seen_q, permit_seen_d;
  logic            permit_level_q, permit_level_d;
  riw_pkg::timer_t permit_age_q, permit_age_d;
  logic            health_seen_q, health_seen_d;
  logic            health_level_q, health_level_d;
  riw_pkg::timer_t health_age_q, health_age_d;
  logic            relay_state_q, relay_state_d;
  logic            feedback_state_q, feedback_state_d;
  logic            mismatch_q, mismatch_d;
  logic            settled_q, settled_d;
  riw_pkg::timer_t since_change_q, since_change_d;

  // Output stage.
  logic             out_valid_q;
  riw_pkg::result_t out_res_q, out_res_d;

  logic in_accept;
  logic event_d;

  // Input word fields.
  logic msg_value, fb_level, fb_valid;
  riw_pkg::opcode_e opcode;

  // Aged counters for a tick.
  riw_pkg::timer_t permit_age_inc, health_age_inc, since_inc;
  logic permit_fresh_tick, health_fresh_tick, want;
  logic permit_fresh_d, health_fresh_d, mis;

  assign cfg_ready_o = 1'b1;

  // The input side is free whenever the output register is empty or drains this cycle.
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  assign msg_value = s_axis_tdata_i[0];
  assign fb_level  = s_axis_tdata_i[1];
  assign fb_valid  = s_axis_tdata_i[2];
  assign opcode    = riw_pkg::opcode_e'(s_axis_tuser_i);

  // Saturating increments: a counter at all ones stays there.
  assign permit_age_inc = (&permit_age_q)   ? permit_age_q   : permit_age_q + 1'b1;
  assign health_age_inc = (&health_age_q)   ? health_age_q   : health_age_q + 1'b1;
  assign since_inc      = (&since_change_q) ? since_change_q : since_change_q + 1'b1;

  // Freshness after the tick has aged both inputs.
  assign permit_fresh_tick = permit_seen_q &
      (riw_pkg::cmp_t'(permit_age_inc) <= riw_pkg::cmp_t'(wdt_timeout_q));
  assign health_fresh_tick = health_seen_q &
      (riw_pkg::cmp_t'(health_age_inc) <= riw_pkg::cmp_t'(wdt_timeout_q));
  assign want = permit_level_q & permit_fresh_tick & health_level_q & health_fresh_tick;

  // Next state for one accepted word.
  always_comb begin
    permit_seen_d    = permit_seen_q;
    permit_level_d   = permit_level_q;
    permit_age_d     = permit_age_q;
    health_seen_d    = health_seen_q;
    health_level_d   = health_level_q;
    health_age_d     = health_age_q;
    relay_state_d    = relay_state_q;
    feedback_state_d = feedback_state_q;
    mismatch_d       = mismatch_q;
    settled_d        = settled_q;
    since_change_d   = since_change_q;
    event_d          = 1'b0;
    mis              = 1'b0;
    unique case (opcode)
      riw_pkg::OP_PERMIT: begin
        permit_seen_d  = 1'b1;
        permit_level_d = msg_value;
        permit_age_d   = '0;
      end
      riw_pkg::OP_HEALTH: begin
        health_seen_d  = 1'b1;
        health_level_d = msg_value;
        health_age_d   = '0;
      end
      riw_pkg::OP_TICK: begin
        permit_age_d     = permit_age_inc;
        health_age_d     = health_age_inc;
        relay_state_d    = want;
        // A new command restarts the settle window; the mismatch flag is judged anew from it.
        since_change_d   = (want != relay_state_q) ? '0 : since_inc;
        feedback_state_d = fb_valid & fb_level;
        settled_d        = riw_pkg::cmp_t'(since_change_d) >=
                           riw_pkg::cmp_t'(settle_time_q);
        mis              = settled_d & (feedback_state_d != want);
        mismatch_d       = mis;
        // The mismatch flag counts as cleared on a command change before it is compared.
        event_d          = (want != relay_state_q) |
                           (mis != ((want != relay_state_q) ? 1'b0 : mismatch_q));
      end
      default: begin
        // Unused opcode: state unchanged, current state reported.
      end
    endcase
  end

  // The result word describes the state after the word.
  assign permit_fresh_d = permit_seen_d &
      (riw_pkg::cmp_t'(permit_age_d) <= riw_pkg::cmp_t'(wdt_timeout_q));
  assign health_fresh_d = health_seen_d &
      (riw_pkg::cmp_t'(health_age_d) <= riw_pkg::cmp_t'(wdt_timeout_q));

  always_comb begin
    out_res_d.relay_drive   = relay_state_d;
    out_res_d.feedback_seen = feedback_state_d;
    out_res_d.settled_now   = settled_d;
    out_res_d.mismatch_now  = mismatch_d;
    out_res_d.status_event  = event_d;
    if (mismatch_d & ~relay_state_d & feedback_state_d) begin
      out_res_d.fault_code = riw_pkg::FAULT_WELDED;
    end else if (mismatch_d & relay_state_d & ~feedback_state_d) begin
      out_res_d.fault_code = riw_pkg::FAULT_NOT_CLOSED;
    end else begin
      out_res_d.fault_code = riw_pkg::FAULT_NONE;
    end
    if (!permit_fresh_d) begin
      out_res_d.permit_cause = riw_pkg::CAUSE_STALE;
    end else if (permit_level_d) begin
      out_res_d.permit_cause = riw_pkg::CAUSE_OK;
    end else begin
      out_res_d.permit_cause = riw_pkg::CAUSE_FALSE;
    end
    if (!health_fresh_d) begin
      out_res_d.health_cause = riw_pkg::CAUSE_STALE;
    end else if (health_level_d) begin
      out_res_d.health_cause = riw_pkg::CAUSE_OK;
    end else begin
      out_res_d.health_cause = riw_pkg::CAUSE_FALSE;
    end
  end

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wdt_timeout_q <= riw_pkg::WdtTimeoutReset;
      settle_time_q <= riw_pkg::SettleTimeReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == riw_pkg::REG_WDT_TIMEOUT) begin
        wdt_timeout_q <= cfg_data_i;
      end
      if (cfg_index_i == riw_pkg::REG_SETTLE_TIME) begin
        settle_time_q <= cfg_data_i;
      end
    end
  end

  // Interlock state, updated once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      permit_seen_q    <= 1'b0;
      permit_level_q   <= 1'b0;
      permit_age_q     <= '0;
      health_seen_q    <= 1'b0;
      health_level_q   <= 1'b0;
      health_age_q     <= '0;
      relay_state_q    <= 1'b0;
      feedback_state_q <= 1'b0;
      mismatch_q       <= 1'b0;
      settled_q        <= 1'b0;
      since_change_q   <= '0;
    end else if (in_accept) begin
      permit_seen_q    <= permit_seen_d;
      permit_level_q   <= permit_level_d;
      permit_age_q     <= permit_age_d;
      health_seen_q    <= health_seen_d;
      health_level_q   <= health_level_d;
      health_age_q     <= health_age_d;
      relay_state_q    <= relay_state_d;
      feedback_state_q <= feedback_state_d;
      mismatch_q       <= mismatch_d;
      settled_q        <= settled_d;
      since_change_q   <= since_change_d;
    end
  end

  // Output register: loads on every accepted word, empties when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(riw_pkg::OutDataWidth - ResWidth){1'b0}}, out_res_q};

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Opcode and register index values that the package leaves unnamed. The block must
  // treat them as no-ops, so the stimulus uses them on purpose.
  localparam logic [1:0]                        OP_UNUSED   = 2'd3;
  localparam logic [riw_pkg::CfgIndexWidth-1:0] REG_SPARE_A = 2'd2;
  localparam logic [riw_pkg::CfgIndexWidth-1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned RES_W       = $bits(riw_pkg::result_t);
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AT     = 200;

  typedef logic [riw_pkg::CfgWidth-1:0] cfg_word_t;

  // One input word as the sender sees it, before it is packed onto the bus.
  typedef struct packed {
    logic [1:0] op;
    logic       mval;
    logic       fbl;
    logic       fbv;
  } stim_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [riw_pkg::CfgIndexWidth-1:0]    cfg_index_i = '0;
  logic [riw_pkg::CfgWidth-1:0]         cfg_data_i = '0;
  logic                                 s_axis_tvalid_i = 1'b0;
  logic                                 s_axis_tready_o;
  logic [riw_pkg::InDataWidth-1:0]      s_axis_tdata_i = '0;
  logic [1:0]                           s_axis_tuser_i = '0;
  logic                                 m_axis_tvalid_o;
  logic                                 m_axis_tready_i = 1'b0;
  logic [riw_pkg::OutDataWidth-1:0]     m_axis_tdata_o;

  relay_interlock_watchdog_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Words waiting to be sent, and the status words the interlock should answer with.
  stim_t            pending_items[$];
  riw_pkg::result_t expected_status[$];

  // Mirror of the interlock state. It starts at the reset values, since reset is
  // applied only once at the start of the run.
  logic [riw_pkg::CfgWidth-1:0] wdt_limit    = riw_pkg::WdtTimeoutReset;
  logic [riw_pkg::CfgWidth-1:0] settle_limit = riw_pkg::SettleTimeReset;
  logic            prm_seen  = 1'b0;
  logic            prm_lvl   = 1'b0;
  riw_pkg::timer_t prm_age   = '0;
  logic            hl_seen   = 1'b0;
  logic            hl_lvl    = 1'b0;
  riw_pkg::timer_t hl_age    = '0;
  logic            drive_q   = 1'b0;
  logic            fb_q      = 1'b0;
  logic            mism_q    = 1'b0;
  logic            settled_q = 1'b0;
  riw_pkg::timer_t since_cmd = '0;

  // Bookkeeping shared between the driver, the monitor and the sequencer.
  bit          sender_busy  = 1'b0;
  stim_t       in_flight;
  int unsigned gap_left     = 0;
  int unsigned tx_calm      = 0;
  int unsigned rx_calm      = 0;
  int unsigned stall_left   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  logic        fb_hold      = 1'b0;

  // Phases of the random part: watchdog timeout and settle time for each one. The
  // last two phases pick their own small values.
  int unsigned wdt_plan[8]    = '{0, 1, 4, 65535, 6, 2, 0, 0};
  int unsigned settle_plan[8] = '{0, 0, 2, 0, 65535, 1, 0, 0};

  // 12 ns clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes. This sits well above the slowest
  // legal run with the longest idle stretches on both sides.
  initial begin
    #(64'd5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic riw_pkg::timer_t sat_up(riw_pkg::timer_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // An input is fresh only once it has been seen and its age is within the timeout.
  function automatic logic is_fresh(logic seen, riw_pkg::timer_t age);
    return seen && (riw_pkg::cmp_t'(age) <= riw_pkg::cmp_t'(wdt_limit));
  endfunction

  function automatic riw_pkg::cause_e input_cause(logic seen, logic lvl,
                                                  riw_pkg::timer_t age);
    if (!is_fresh(seen, age)) begin
      return riw_pkg::CAUSE_STALE;
    end
    if (lvl) begin
      return riw_pkg::CAUSE_OK;
    end
    return riw_pkg::CAUSE_FALSE;
  endfunction

  // Advances the mirrored interlock by one input word and returns the status word
  // that the block must report for it.
  function automatic riw_pkg::result_t step_interlock(stim_t s);
    riw_pkg::result_t r;
    logic             close_cmd;
    logic             mis_now;
    logic             evt;
    evt = 1'b0;
    case (s.op)
      riw_pkg::OP_PERMIT: begin
        prm_seen = 1'b1;
        prm_lvl  = s.mval;
        prm_age  = '0;
      end
      riw_pkg::OP_HEALTH: begin
        hl_seen = 1'b1;
        hl_lvl  = s.mval;
        hl_age  = '0;
      end
      riw_pkg::OP_TICK: begin
        prm_age   = sat_up(prm_age);
        hl_age    = sat_up(hl_age);
        since_cmd = sat_up(since_cmd);
        close_cmd = prm_lvl && is_fresh(prm_seen, prm_age) &&
                    hl_lvl && is_fresh(hl_seen, hl_age);
        // A new command restarts the settle window and drops any pending mismatch.
        if (close_cmd != drive_q) begin
          drive_q   = close_cmd;
          since_cmd = '0;
          mism_q    = 1'b0;
          evt       = 1'b1;
        end
        // A failed read counts as an open contact, i.e. a dead rail.
        fb_q      = s.fbv && s.fbl;
        settled_q = riw_pkg::cmp_t'(since_cmd) >= riw_pkg::cmp_t'(settle_limit);
        mis_now   = settled_q && (fb_q != drive_q);
        if (mis_now != mism_q) begin
          mism_q = mis_now;
          evt    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    r.relay_drive   = drive_q;
    r.feedback_seen = fb_q;
    r.settled_now   = settled_q;
    r.mismatch_now  = mism_q;
    r.fault_code    = riw_pkg::FAULT_NONE;
    if (mism_q && !drive_q && fb_q) begin
      r.fault_code = riw_pkg::FAULT_WELDED;
    end else if (mism_q && drive_q && !fb_q) begin
      r.fault_code = riw_pkg::FAULT_NOT_CLOSED;
    end
    r.permit_cause = input_cause(prm_seen, prm_lvl, prm_age);
    r.health_cause = input_cause(hl_seen, hl_lvl, hl_age);
    r.status_event = evt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_t make_stim(logic [1:0] op, logic mval, logic fbl, logic fbv);
    stim_t s;
    s.op   = op;
    s.mval = mval;
    s.fbl  = fbl;
    s.fbv  = fbv;
    return s;
  endfunction

  // Mostly ticks and mostly true messages, so the relay actually gets to close and
  // settle. The feedback pin is sticky so that settled windows with agreeing and
  // disagreeing feedback both last a while; unused bits of messages stay random.
  function automatic stim_t random_stim();
    int unsigned r;
    stim_t       s;
    r = $urandom_range(0, 99);
    s = make_stim(riw_pkg::OP_TICK, 1'($urandom), 1'($urandom), 1'($urandom));
    if (r < 4) begin
      s.op = OP_UNUSED;
    end else if (r < 24) begin
      s.op   = riw_pkg::OP_PERMIT;
      s.mval = ($urandom_range(0, 9) != 0);
    end else if (r < 44) begin
      s.op   = riw_pkg::OP_HEALTH;
      s.mval = ($urandom_range(0, 9) != 0);
    end else begin
      if ($urandom_range(0, 6) == 0) begin
        fb_hold = ~fb_hold;
      end
      s.fbl = fb_hold;
      s.fbv = ($urandom_range(0, 9) != 0);
    end
    return s;
  endfunction

  // Length of the next idle stretch: mostly none, often a few cycles, now and then a
  // long one. Occasionally a calm run of several dozen words with no idling at all.
  function automatic int unsigned idle_cycles(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: pops pending words, holds each until it is taken, and predicts the
  // status word at the edge where the handshake completes.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_status.push_back(step_interlock(in_flight));
        sender_busy = 1'b0;
      end
      if (!sender_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_flight   = pending_items.pop_front();
          sender_busy = 1'b1;
          gap_left    = idle_cycles(tx_calm);
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {{(riw_pkg::InDataWidth - 3){1'b0}}, in_flight.fbv,
                              in_flight.fbl, in_flight.mval};
          s_axis_tuser_i  <= in_flight.op;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares each status word with the oldest prediction and plays
  // the receiver's back-pressure. Once, partway through the random part, it holds
  // off for a long stretch so the output register fills and the input stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    riw_pkg::result_t got;
    riw_pkg::result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = riw_pkg::result_t'(m_axis_tdata_o[RES_W-1:0]);
        if (expected_status.size() == 0) begin
          fail_count++;
          $error("status word with nothing expected: %0h", m_axis_tdata_o);
        end else begin
          want = expected_status.pop_front();
          check_field("relay_drive", want.relay_drive, got.relay_drive);
          check_field("feedback_seen", want.feedback_seen, got.feedback_seen);
          check_field("settled_now", want.settled_now, got.settled_now);
          check_field("mismatch_now", want.mismatch_now, got.mismatch_now);
          check_field("fault_code", want.fault_code, got.fault_code);
          check_field("permit_cause", want.permit_cause, got.permit_cause);
          check_field("health_cause", want.health_cause, got.health_cause);
          check_field("status_event", want.status_event, got.status_event);
        end
        results_seen++;
        if (results_seen == HOLD_AT) begin
          stall_left = LONG_HOLD;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = idle_cycles(rx_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  // Waits until every queued word has been sent and every status word has come back.
  // Each word yields exactly one status word, so the block is idle at that point; a
  // few extra cycles cover the output register.
  task automatic wait_idle();
    while (pending_items.size() != 0 || sender_busy || expected_status.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  // Register writes happen only while the interlock is idle, so the mirror can take
  // the new value at the handshake.
  task automatic write_reg(logic [riw_pkg::CfgIndexWidth-1:0] idx,
                           logic [riw_pkg::CfgWidth-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      riw_pkg::REG_WDT_TIMEOUT: wdt_limit = val;
      riw_pkg::REG_SETTLE_TIME: settle_limit = val;
      default: begin
      end
    endcase
  endtask

  initial begin : sequencer
    int unsigned wdt_pick;
    int unsigned settle_pick;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A first batch runs on the reset values of both registers.
    repeat (60) pending_items.push_back(random_stim());
    wait_idle();

    // Writes to the unused register indexes must leave the settings alone.
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(riw_pkg::REG_WDT_TIMEOUT, 16'd3);
    write_reg(riw_pkg::REG_SETTLE_TIME, 16'd2);
    write_reg(REG_SPARE_B, 16'hFFFF);

    // Directed walk through the interlock with a timeout of 3 and a settle time of 2.
    // Unreadable feedback on a tick, then the unused opcode with every bit set.
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b1, 1'b0));
    pending_items.push_back(make_stim(OP_UNUSED, 1'b1, 1'b1, 1'b1));
    // A false permit keeps the relay open even with health true.
    pending_items.push_back(make_stim(riw_pkg::OP_PERMIT, 1'b0, 1'b1, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_HEALTH, 1'b1, 1'b0, 1'b0));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b0, 1'b1));
    // Both true: the relay closes, then a dead rail turns into a not-closed fault.
    pending_items.push_back(make_stim(riw_pkg::OP_PERMIT, 1'b1, 1'b0, 1'b0));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b1, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b0, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_PERMIT, 1'b1, 1'b0, 1'b0));
    pending_items.push_back(make_stim(riw_pkg::OP_HEALTH, 1'b1, 1'b0, 1'b0));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b0, 1'b1));
    // A live rail clears the fault, an unreadable one brings it back.
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b1, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b1, 1'b0));
    // The inputs go stale, the relay opens, and a live rail reads as welded.
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b1, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b1, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b1, 1'b1));
    // A false health input while the permit is fresh.
    pending_items.push_back(make_stim(riw_pkg::OP_HEALTH, 1'b0, 1'b1, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_PERMIT, 1'b1, 1'b1, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b0, 1'b1));
    pending_items.push_back(make_stim(riw_pkg::OP_HEALTH, 1'b1, 1'b0, 1'b0));
    pending_items.push_back(make_stim(riw_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    wait_idle();

    // Random part, one phase per setting, extremes included.
    for (int p = 0; p < 8; p++) begin
      wdt_pick    = (p < 6) ? wdt_plan[p] : $urandom_range(1, 10);
      settle_pick = (p < 6) ? settle_plan[p] : $urandom_range(0, 6);
      write_reg(riw_pkg::REG_WDT_TIMEOUT, cfg_word_t'(wdt_pick));
      write_reg(riw_pkg::REG_SETTLE_TIME, cfg_word_t'(settle_pick));
      if (p == 3) begin
        write_reg(REG_SPARE_B, 16'($urandom));
      end
      repeat (100) pending_items.push_back(random_stim());
      wait_idle();
    end

    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && expected_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
